>>> hdl/mkpd_pkg.sv
// Package for the matrix keypad scanner: key state types, status and event codes,
// reset values and the per-key debounce update function. No dependencies.
`default_nettype none

package mkpd_pkg;

    localparam int ROWS_DEFAULT    = 4;
    localparam int COLUMNS_DEFAULT = 4;

    localparam logic [7:0] DEBOUNCE_RESET  = 8'd4;
    localparam logic [7:0] LONGPRESS_RESET = 8'd100;
    localparam logic [7:0] COUNT_MAX       = 8'd255;

    localparam logic [1:0] ST_RELEASED = 2'd0;
    localparam logic [1:0] ST_PRESSED  = 2'd1;
    localparam logic [1:0] ST_LONG     = 2'd2;
    localparam logic [1:0] ST_UNUSED   = 2'd3;

    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_PRESS   = 2'd1;
    localparam logic [1:0] EV_LONG    = 2'd2;
    localparam logic [1:0] EV_RELEASE = 2'd3;

    localparam logic REG_DEBOUNCE  = 1'b0;
    localparam logic REG_LONGPRESS = 1'b1;

    typedef struct packed {
        logic       raw;
        logic [1:0] status;
        logic [7:0] count;
    } key_state_t;

    typedef struct packed {
        key_state_t st;
        logic [1:0] ev;
    } key_result_t;

    function automatic key_result_t key_update(key_state_t s, logic pressed,
                                               logic [7:0] db, logic [7:0] lp);
        key_result_t res;
        logic [7:0]  thr;
        thr = (db == 8'd0) ? 8'd1 : db;
        res.st = s;
        res.ev = EV_NONE;
        if (s.raw == pressed) begin
            if (({1'b0, s.raw} != s.status) || (s.status != ST_RELEASED)) begin
                if (s.count != COUNT_MAX) begin
                    res.st.count = s.count + 8'd1;
                end
            end
        end else begin
            res.st.count = 8'd0;
            res.st.raw   = pressed;
        end
        if (res.st.count >= thr) begin
            if (res.st.raw) begin
                if (res.st.status == ST_RELEASED) begin
                    res.st.status = ST_PRESSED;
                    res.ev        = EV_PRESS;
                end else if (res.st.status == ST_PRESSED) begin
                    if (res.st.count >= lp) begin
                        res.st.status = ST_LONG;
                        res.ev        = EV_LONG;
                    end
                end
            end else begin
                res.st.status = ST_RELEASED;
                res.st.count  = 8'd0;
                res.ev        = EV_RELEASE;
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> hdl/matrix_keypad_scan_debounce.sv
// Matrix keypad scanner with per-key debounce and long-press detection.
// The result of a transaction is in the output register in the cycle after it is accepted.
// Throughput: one transaction per cycle while in_stall is low; each one updates the scanned column's keys.
// Reset: all keys released with cleared counters, scan at column 0.
// Reset also loads the debounce threshold with 4 and the long-press threshold with 100.
// Depends on mkpd_pkg.
`default_nettype none

module matrix_keypad_scan_debounce #(
    parameter int ROWS    = mkpd_pkg::ROWS_DEFAULT,
    parameter int COLUMNS = mkpd_pkg::COLUMNS_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [3:0]  row_levels,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [1:0]  scanned_column,
    output logic      [1:0]  event_row_zero,
    output logic      [1:0]  event_row_one,
    output logic      [1:0]  event_row_two,
    output logic      [1:0]  event_row_three,
    output logic      [1:0]  drive_column
);

    import mkpd_pkg::*;

    localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);

    logic [7:0]       db_reg;
    logic [7:0]       lp_reg;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    key_state_t       keys_reg [COLUMNS][ROWS];
    key_result_t      key_next [ROWS];
    logic [7:0]       levels_ext;
    logic [1:0]       ev_next [4];
    logic             out_valid_reg;
    logic [1:0]       scanned_reg;
    logic [1:0]       drive_reg;
    logic [1:0]       ev_reg [4];
    logic             accept;
    logic             cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == REG_LONGPRESS) ? {24'd0, lp_reg} : {24'd0, db_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            db_reg <= DEBOUNCE_RESET;
            lp_reg <= LONGPRESS_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_DEBOUNCE)
            begin
                db_reg <= pwdata[7:0];
            end
            else
            begin
                lp_reg <= pwdata[7:0];
            end
        end
    end

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    // Rows beyond the four input bits read as not pressed.
    assign levels_ext = {4'hF, row_levels};
    assign col_next   = (col_reg == COL_LAST) ? '0 : col_reg + COL_W'(1);

    always_comb
    begin
        for (int e = 0; e < 4; e++)
        begin
            ev_next[e] = EV_NONE;
        end
        for (int r = 0; r < ROWS; r++)
        begin
            key_next[r] = key_update(keys_reg[col_reg][r], ~levels_ext[r], db_reg, lp_reg);
            if (r < 4)
            begin
                ev_next[r] = key_next[r].ev;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            for (int c = 0; c < COLUMNS; c++)
            begin
                for (int r = 0; r < ROWS; r++)
                begin
                    keys_reg[c][r] <= '{raw: 1'b0, status: ST_RELEASED, count: 8'd0};
                end
            end
        end
        else if (accept)
        begin
            col_reg <= col_next;
            for (int r = 0; r < ROWS; r++)
            begin
                keys_reg[col_reg][r] <= key_next[r].st;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            scanned_reg <= 2'(col_reg);
            drive_reg   <= 2'(col_next);
            for (int e = 0; e < 4; e++)
            begin
                ev_reg[e] <= ev_next[e];
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign scanned_column  = scanned_reg;
    assign drive_column    = drive_reg;
    assign event_row_zero  = ev_reg[0];
    assign event_row_one   = ev_reg[1];
    assign event_row_two   = ev_reg[2];
    assign event_row_three = ev_reg[3];

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted transaction did not produce a result");

    a_scan_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && col_reg == COL_LAST) |=> col_reg == '0)
        else $error("scan did not wrap after the last column");

    a_idle_holds_column: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(col_reg))
        else $error("scan column moved without a transaction");

    a_no_unused_status: assert property (@(posedge clk) disable iff (!rst_n)
        keys_reg[col_reg][0].status != ST_UNUSED)
        else $error("key status holds the unused code");

endmodule

`default_nettype wire
